// ===== sv/st_pkg.sv =====
// shared types and constants for the span tracker
`default_nettype none

package st_pkg;

    // fixed field widths
    localparam int VALUE_W          = 32;
    localparam int COUNT_W          = 11;
    localparam int TDATA_W          = 80;
    localparam int TUSER_W          = 2;
    localparam int CAPACITY_DEFAULT = 1024;

    // flipping the sign bit makes unsigned order match signed order
    localparam logic [VALUE_W-1:0] SIGN_BIAS = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] GAP_INIT  = {VALUE_W{1'b1}};

    // status codes
    localparam logic STATUS_STORED = 1'b0;
    localparam logic STATUS_FULL   = 1'b1;

    // one item travelling down the cell row
    typedef struct packed {
        logic               valid;
        logic               status;
        logic [COUNT_W-1:0] slot;
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] gap;
        logic [VALUE_W-1:0] span;
    } item_t;

endpackage

`default_nettype wire

// ===== sv/st_cell.sv =====
// one cell of the row: holds one value and folds its gap into a passing item
`default_nettype none

module st_cell #(
    parameter int INDEX = 0
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         advance,
    input  wire st_pkg::item_t item_in,
    output st_pkg::item_t     item_out
);
    import st_pkg::*;

    logic [VALUE_W-1:0] stored_reg;
    item_t              item_reg;
    item_t              item_next;
    logic [VALUE_W-1:0] diff;
    logic               cmp_en;
    logic               store_en;

    // gap against the held value, only for items placed above this slot
    always_comb
    begin
        cmp_en   = item_in.valid && (item_in.status == STATUS_STORED)
                   && (32'(item_in.slot) > 32'(INDEX));
        store_en = advance && item_in.valid && (item_in.status == STATUS_STORED)
                   && (32'(item_in.slot) == 32'(INDEX));
        diff     = (item_in.value > stored_reg) ? (item_in.value - stored_reg)
                                                : (stored_reg - item_in.value);
        item_next = item_in;
        if (cmp_en && (diff < item_in.gap))
        begin
            item_next.gap = diff;
        end
    end

    // held value, written once by the item whose slot matches
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            stored_reg <= item_in.value;
        end
    end

    // stage register toward the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg.valid <= 1'b0;
        end
        else if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

`default_nettype wire

// ===== sv/span_tracker.sv =====
// top level: entry logic, row of value cells and result register
`default_nettype none

// Accepts one value per cycle whenever the result register is free or being
// taken, and returns one result per value, in order, after it has passed the
// row of CAPACITY cells and the result register. Every item passes each cell,
// one register stage per cell, comparing itself with the value held there and
// keeping the smallest gap; the item whose slot matches a cell leaves its value
// in it. A stalled output holds the whole row. Count, smallest and largest
// values are kept at the entry, the running shortest gap at the tail. The cells
// need no clearing after reset. max_count is written through the cfg channel,
// which is always ready; the user must write it only while idle (not enforced).

module span_tracker #(
    parameter int CAPACITY = st_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // cfg_data: max_count[10:0]
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [st_pkg::COUNT_W-1:0]   cfg_data,
    // s_axis_tdata: value[31:0]
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [st_pkg::VALUE_W-1:0]   s_axis_tdata,
    // m_axis_tdata: stored_count[10:0], shortest_span[42:11],
    //               longest_span[74:43], zero[79:75]
    // m_axis_tuser: status[0], span_valid[1]
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [st_pkg::TDATA_W-1:0]        m_axis_tdata,
    output logic [st_pkg::TUSER_W-1:0]        m_axis_tuser
);
    import st_pkg::*;

    localparam int PAD_W = TDATA_W - COUNT_W - 2 * VALUE_W;

    logic [COUNT_W-1:0] max_count_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [VALUE_W-1:0] smallest_reg, smallest_next;
    logic [VALUE_W-1:0] largest_reg, largest_next;
    logic [VALUE_W-1:0] min_gap_reg, min_gap_next;
    logic [COUNT_W-1:0] limit;
    logic               full;
    logic               advance;
    logic               accept;
    logic [VALUE_W-1:0] biased;
    item_t              chain [0:CAPACITY];
    item_t              tail;

    logic               out_valid_reg;
    logic               status_reg;
    logic               span_valid_reg;
    logic [COUNT_W-1:0] count_out_reg;
    logic [VALUE_W-1:0] shortest_reg;
    logic [VALUE_W-1:0] longest_reg;
    logic               tail_span_valid;

    // row moves whenever the result register can take a beat
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;
    assign cfg_ready     = 1'b1;

    // effective limit and entry bookkeeping
    always_comb
    begin
        limit  = (32'(max_count_reg) < 32'(CAPACITY)) ? max_count_reg
                                                      : COUNT_W'(CAPACITY);
        full   = (count_reg >= limit);
        biased = s_axis_tdata ^ SIGN_BIAS;
        count_next    = count_reg;
        smallest_next = smallest_reg;
        largest_next  = largest_reg;
        if (!full)
        begin
            count_next = count_reg + COUNT_W'(1);
            if (count_reg == '0)
            begin
                smallest_next = biased;
                largest_next  = biased;
            end
            else
            begin
                if (biased < smallest_reg)
                begin
                    smallest_next = biased;
                end
                if (biased > largest_reg)
                begin
                    largest_next = biased;
                end
            end
        end
    end

    // item entering the first cell
    always_comb
    begin
        chain[0].valid  = s_axis_tvalid;
        chain[0].status = full ? STATUS_FULL : STATUS_STORED;
        chain[0].slot   = count_reg;
        chain[0].count  = count_next;
        chain[0].value  = biased;
        chain[0].gap    = GAP_INIT;
        chain[0].span   = largest_next - smallest_next;
    end

    // config register and entry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_count_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_count_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // extremes are meaningful only once a value is held
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smallest_reg <= smallest_next;
            largest_reg  <= largest_next;
        end
    end

    // row of cells
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        st_cell #(
            .INDEX (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .item_in  (chain[k]),
            .item_out (chain[k+1])
        );
    end

    assign tail = chain[CAPACITY];

    // running shortest gap at the tail
    always_comb
    begin
        min_gap_next = min_gap_reg;
        if ((tail.status == STATUS_STORED) && (tail.gap < min_gap_reg))
        begin
            min_gap_next = tail.gap;
        end
        tail_span_valid = (tail.count >= COUNT_W'(2));
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            min_gap_reg   <= GAP_INIT;
        end
        else if (advance)
        begin
            out_valid_reg <= tail.valid;
            if (tail.valid)
            begin
                min_gap_reg <= min_gap_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tail.valid)
        begin
            status_reg     <= tail.status;
            span_valid_reg <= tail_span_valid;
            count_out_reg  <= tail.count;
            shortest_reg   <= tail_span_valid ? min_gap_next : '0;
            longest_reg    <= tail_span_valid ? tail.span : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, longest_reg, shortest_reg, count_out_reg};
    assign m_axis_tuser  = {span_valid_reg, status_reg};

endmodule

`default_nettype wire

// ===== sv/st_checker.sv =====
// port-level checks for the span tracker and their binding
`default_nettype none

module st_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [st_pkg::TDATA_W-1:0] m_axis_tdata,
    input wire logic [st_pkg::TUSER_W-1:0] m_axis_tuser
);
    import st_pkg::*;

    // reset empties the result register
    assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result beat shown during reset");

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    // span flag follows the count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[1] == (m_axis_tdata[10:0] >= 11'd2))
        else $error("span flag disagrees with count");

    // spans read zero when not valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[74:11] == '0)
        else $error("spans nonzero without two values");

    // shortest gap never exceeds the full range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[42:11] <= m_axis_tdata[74:43])
        else $error("shortest span above longest span");

endmodule

bind span_tracker st_checker u_st_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
